[hdl/pbd_pkg.sv]
// ----------------------------------------------------------------------------
// PackBytes page decoder package
// Shared widths, state codes and the run descriptor passed from the stream
// parser to the group expander.
// ----------------------------------------------------------------------------
package pbd_pkg;

   localparam int PAGE_BYTES = 8192;
   localparam int MAX_COUNT  = 64;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = $clog2(MAX_COUNT + 1);
   localparam int TOTAL_W  = $clog2(4 * MAX_COUNT + 1);
   localparam int CAP_W    = $clog2(2 * PAGE_BYTES + 1);
   localparam int OFFSET_W = 15;
   localparam int LANE_W   = 3;
   localparam int PAT_W    = 4 * BYTE_W;

   localparam logic [1:0] KIND_LIT  = 2'd0;
   localparam logic [1:0] KIND_REP  = 2'd1;
   localparam logic [1:0] KIND_QUAD = 2'd2;
   localparam logic [1:0] KIND_FILL = 2'd3;

   localparam logic [1:0] QUAD_LAST = 2'd3;

   typedef enum logic [2:0] {
      EXP_TAG  = 3'd0,
      EXP_LIT  = 3'd1,
      EXP_REP  = 3'd2,
      EXP_QUAD = 3'd3,
      EXP_FILL = 3'd4
   } expect_type;

   typedef struct packed {
      logic               is_end;
      logic [PAT_W-1:0]   pattern;
      logic [TOTAL_W-1:0] total;
   } job_type;

endpackage

[hdl/pbd_if.sv]
// ----------------------------------------------------------------------------
// PackBytes page decoder channels
// Valid/ready request channel carrying stream bytes, and response channel
// carrying output byte groups.
// ----------------------------------------------------------------------------
interface pbd_req_if;
   logic                     valid;
   logic                     ready;
   logic [pbd_pkg::BYTE_W-1:0] data_byte;
   logic                     stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface pbd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pbd_pkg::BYTE_W-1:0]   byte_a;
   logic [pbd_pkg::BYTE_W-1:0]   byte_b;
   logic [pbd_pkg::BYTE_W-1:0]   byte_c;
   logic [pbd_pkg::BYTE_W-1:0]   byte_d;
   logic [pbd_pkg::LANE_W-1:0]   lane_count;
   logic [pbd_pkg::OFFSET_W-1:0] page_offset;
   logic                         last;
   logic                         empty_stream;

   modport source (output valid, output byte_a, output byte_b, output byte_c,
                   output byte_d, output lane_count, output page_offset,
                   output last, output empty_stream, input ready);
   modport sink   (input valid, input byte_a, input byte_b, input byte_c,
                   input byte_d, input lane_count, input page_offset,
                   input last, input empty_stream, output ready);
endinterface

[hdl/pbd_parser.sv]
// ----------------------------------------------------------------------------
// PackBytes stream parser
// Tracks tag and packet bytes and turns each completed packet step into a
// run descriptor held in a one-entry job register.
// ----------------------------------------------------------------------------
module pbd_parser (
   input  logic              clock,
   input  logic              reset,
   pbd_req_if.sink           req_chan,
   output logic              job_valid,
   output pbd_pkg::job_type  job,
   input  logic              job_pop
);

   pbd_pkg::expect_type                expect_ff, expect_in;
   logic [pbd_pkg::COUNT_W-1:0]        remaining_ff, remaining_in;
   logic [pbd_pkg::PAT_W-1:0]          quad_ff, quad_in;
   logic [1:0]                         quad_idx_ff, quad_idx_in;
   logic                               job_valid_ff, job_valid_in;
   pbd_pkg::job_type                   job_ff, job_in;

   logic                               accept;
   logic                               make_job;
   logic [pbd_pkg::BYTE_W-1:0]         b;
   logic [pbd_pkg::PAT_W-1:0]          quad_new;
   logic [pbd_pkg::TOTAL_W-1:0]        rem_total;
   logic [pbd_pkg::TOTAL_W-1:0]        rem4_total;

   assign b          = req_chan.data_byte;
   assign req_chan.ready = !job_valid_ff || job_pop;
   assign accept     = req_chan.valid && req_chan.ready;
   assign rem_total  = pbd_pkg::TOTAL_W'(remaining_ff);
   assign rem4_total = pbd_pkg::TOTAL_W'({remaining_ff, 2'b00});
   assign quad_new   = quad_ff | (pbd_pkg::PAT_W'(b) << {quad_idx_ff, 3'b000});

   always_comb begin
      expect_in = expect_ff;
      if (accept) begin
         if (req_chan.stream_end) begin
            expect_in = pbd_pkg::EXP_TAG;
         end else begin
            case (expect_ff)
               pbd_pkg::EXP_TAG: begin
                  case (b[7:6])
                     pbd_pkg::KIND_LIT:  expect_in = pbd_pkg::EXP_LIT;
                     pbd_pkg::KIND_REP:  expect_in = pbd_pkg::EXP_REP;
                     pbd_pkg::KIND_QUAD: expect_in = pbd_pkg::EXP_QUAD;
                     default:            expect_in = pbd_pkg::EXP_FILL;
                  endcase
               end
               pbd_pkg::EXP_LIT: begin
                  if (remaining_ff <= pbd_pkg::COUNT_W'(1)) expect_in = pbd_pkg::EXP_TAG;
               end
               pbd_pkg::EXP_QUAD: begin
                  if (quad_idx_ff == pbd_pkg::QUAD_LAST) expect_in = pbd_pkg::EXP_TAG;
               end
               default: expect_in = pbd_pkg::EXP_TAG;
            endcase
         end
      end
   end

   always_comb begin
      remaining_in   = remaining_ff;
      quad_in        = quad_ff;
      quad_idx_in    = quad_idx_ff;
      make_job       = 1'b0;
      job_in.is_end  = 1'b0;
      job_in.pattern = '0;
      job_in.total   = '0;
      if (accept) begin
         if (req_chan.stream_end) begin
            make_job      = 1'b1;
            job_in.is_end = 1'b1;
            case (expect_ff)
               pbd_pkg::EXP_LIT:  job_in.total = rem_total;
               pbd_pkg::EXP_REP:  job_in.total = rem_total;
               pbd_pkg::EXP_FILL: job_in.total = rem4_total;
               pbd_pkg::EXP_QUAD: begin
                  job_in.pattern = quad_ff;
                  job_in.total   = rem4_total;
               end
               default: job_in.total = '0;
            endcase
            remaining_in = '0;
            quad_in      = '0;
            quad_idx_in  = '0;
         end else begin
            case (expect_ff)
               pbd_pkg::EXP_TAG: begin
                  remaining_in = pbd_pkg::COUNT_W'(b[5:0]) + pbd_pkg::COUNT_W'(1);
                  quad_in      = '0;
                  quad_idx_in  = '0;
               end
               pbd_pkg::EXP_LIT: begin
                  make_job       = 1'b1;
                  job_in.pattern = pbd_pkg::PAT_W'(b);
                  job_in.total   = pbd_pkg::TOTAL_W'(1);
                  if (remaining_ff != '0) remaining_in = remaining_ff - pbd_pkg::COUNT_W'(1);
               end
               pbd_pkg::EXP_REP: begin
                  make_job       = 1'b1;
                  job_in.pattern = {4{b}};
                  job_in.total   = rem_total;
                  remaining_in   = '0;
               end
               pbd_pkg::EXP_FILL: begin
                  make_job       = 1'b1;
                  job_in.pattern = {4{b}};
                  job_in.total   = rem4_total;
                  remaining_in   = '0;
               end
               pbd_pkg::EXP_QUAD: begin
                  quad_in = quad_new;
                  if (quad_idx_ff == pbd_pkg::QUAD_LAST) begin
                     make_job       = 1'b1;
                     job_in.pattern = quad_new;
                     job_in.total   = rem4_total;
                     remaining_in   = '0;
                     quad_idx_in    = '0;
                  end else begin
                     quad_idx_in = quad_idx_ff + 2'd1;
                  end
               end
               default: remaining_in = remaining_ff;
            endcase
         end
      end
   end

   always_comb begin
      job_valid_in = job_valid_ff && !job_pop;
      if (make_job) job_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff    <= pbd_pkg::EXP_TAG;
         remaining_ff <= '0;
         quad_ff      <= '0;
         quad_idx_ff  <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         expect_ff    <= expect_in;
         remaining_ff <= remaining_in;
         quad_ff      <= quad_in;
         quad_idx_ff  <= quad_idx_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (make_job) job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

[hdl/pbd_expander.sv]
// ----------------------------------------------------------------------------
// PackBytes group expander
// Walks one run descriptor four bytes per cycle when not stalled, clips at
// the page capacity and drives the registered response channel incl. end report.
// ----------------------------------------------------------------------------
module pbd_expander (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic              csr_write_data,
   input  logic              job_valid,
   input  pbd_pkg::job_type  job,
   output logic              job_pop,
   pbd_rsp_if.source         rsp_chan
);

   logic                            double_ff;
   logic [pbd_pkg::TOTAL_W-1:0]     pos_ff, pos_in;
   logic [pbd_pkg::CAP_W-1:0]       bw_ff, bw_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pbd_pkg::BYTE_W-1:0]      byte_a_ff, byte_b_ff, byte_c_ff, byte_d_ff;
   logic [pbd_pkg::BYTE_W-1:0]      byte_a_in, byte_b_in, byte_c_in, byte_d_in;
   logic [pbd_pkg::LANE_W-1:0]      lanes_ff, lanes_in;
   logic [pbd_pkg::OFFSET_W-1:0]    offset_ff, offset_in;
   logic                            last_ff, last_in;
   logic                            empty_ff, empty_in;

   logic [pbd_pkg::CAP_W-1:0]       cap;
   logic [pbd_pkg::CAP_W-1:0]       room;
   logic [pbd_pkg::CAP_W-1:0]       bw_next;
   logic [pbd_pkg::TOTAL_W-1:0]     rem_total;
   logic [pbd_pkg::TOTAL_W:0]       pos_step;
   logic [pbd_pkg::LANE_W-1:0]      lanes_total;
   logic [pbd_pkg::LANE_W-1:0]      lanes;
   logic                            active, more, done, out_free, step, emit;

   assign cap       = double_ff ? pbd_pkg::CAP_W'(2 * pbd_pkg::PAGE_BYTES)
                                : pbd_pkg::CAP_W'(pbd_pkg::PAGE_BYTES);
   assign active    = (pos_ff < job.total) && (bw_ff < cap);
   assign rem_total = job.total - pos_ff;
   assign room      = cap - bw_ff;
   assign pos_step  = {1'b0, pos_ff} + (pbd_pkg::TOTAL_W + 1)'(4);

   always_comb begin
      lanes_total = (rem_total > pbd_pkg::TOTAL_W'(4)) ? pbd_pkg::LANE_W'(4)
                                                      : rem_total[pbd_pkg::LANE_W-1:0];
      lanes = lanes_total;
      if (room < pbd_pkg::CAP_W'(lanes_total)) lanes = room[pbd_pkg::LANE_W-1:0];
      if (!active) lanes = '0;
   end

   assign bw_next  = bw_ff + pbd_pkg::CAP_W'(lanes);
   assign more     = active && (pos_step < {1'b0, job.total}) && (bw_next < cap);
   assign done     = !more;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign step     = job_valid && out_free;
   assign emit     = step && (active || job.is_end);
   assign job_pop  = step && done;

   always_comb begin
      byte_a_in = (lanes > pbd_pkg::LANE_W'(0)) ? job.pattern[7:0]   : '0;
      byte_b_in = (lanes > pbd_pkg::LANE_W'(1)) ? job.pattern[15:8]  : '0;
      byte_c_in = (lanes > pbd_pkg::LANE_W'(2)) ? job.pattern[23:16] : '0;
      byte_d_in = (lanes > pbd_pkg::LANE_W'(3)) ? job.pattern[31:24] : '0;
      lanes_in  = lanes;
      offset_in = pbd_pkg::OFFSET_W'(bw_ff);
      last_in   = job.is_end && done;
      empty_in  = job.is_end && done && (bw_next == '0);
   end

   always_comb begin
      pos_in = pos_ff;
      bw_in  = bw_ff;
      if (step) begin
         pos_in = done ? '0 : pos_step[pbd_pkg::TOTAL_W-1:0];
         bw_in  = (job.is_end && done) ? '0 : bw_next;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         double_ff    <= 1'b0;
         pos_ff       <= '0;
         bw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) double_ff <= csr_write_data;
         pos_ff       <= pos_in;
         bw_ff        <= bw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_a_ff <= byte_a_in;
         byte_b_ff <= byte_b_in;
         byte_c_ff <= byte_c_in;
         byte_d_ff <= byte_d_in;
         lanes_ff  <= lanes_in;
         offset_ff <= offset_in;
         last_ff   <= last_in;
         empty_ff  <= empty_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.byte_a       = byte_a_ff;
   assign rsp_chan.byte_b       = byte_b_ff;
   assign rsp_chan.byte_c       = byte_c_ff;
   assign rsp_chan.byte_d       = byte_d_ff;
   assign rsp_chan.lane_count   = lanes_ff;
   assign rsp_chan.page_offset  = offset_ff;
   assign rsp_chan.last         = last_ff;
   assign rsp_chan.empty_stream = empty_ff;

`ifndef SYNTH
   a_short_group_zero_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (lanes_ff < pbd_pkg::LANE_W'(4)) |-> (byte_d_ff == '0))
      else $error("unused lane carries data");

   a_report_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (lanes_ff == '0) |-> last_ff)
      else $error("empty group that is not the end report");

   a_empty_is_pure_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && empty_ff |-> last_ff && (lanes_ff == '0))
      else $error("empty flag on a data group");

   a_end_clears_fill: assert property (@(posedge clock) disable iff (reset)
      emit && last_in |=> (bw_ff == '0) && (pos_ff == '0))
      else $error("fill point not cleared after end report");
`endif

endmodule

[hdl/packbytes_page_decoder_unit.sv]
// ----------------------------------------------------------------------------
// PackBytes page decoder
// Expands a PackBytes stream into page byte groups with their page offsets.
// ----------------------------------------------------------------------------
//   channel    direction  carries
//   req_chan   in         data_byte, stream_end
//   rsp_chan   out        byte_a..byte_d, lane_count, page_offset, last, empty
//   csr_*      in         double_page
//
// Tag bytes and quad pattern bytes other than the last only update parser state.
// A run of N output bytes is emitted one group per cycle unless the response
// stalls, stopping early once the page is full; the run is held in the job
// register, each group in the response register, and req_chan ready stays low until the last group.
// Reset is synchronous and returns to single page and tag expected.
// A stalled response holds the expander; requests are still taken while the
// job register is free.
module packbytes_page_decoder_unit (
   input  logic     clock,
   input  logic     reset,
   pbd_req_if.sink  req_chan,
   pbd_rsp_if.source rsp_chan,
   input  logic     csr_write_en,
   input  logic     csr_write_data
);

   logic              job_valid;
   logic              job_pop;
   pbd_pkg::job_type  job;

   pbd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   pbd_expander u_expander (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .job_valid      (job_valid),
      .job            (job),
      .job_pop        (job_pop),
      .rsp_chan       (rsp_chan)
   );

endmodule
